// ----- hw/rtl/nrl_pkg.sv -----
// Shared types and constants for the node registry with liveness tracking.
package nrl_pkg;

    // Operation codes carried by each input item
    typedef enum logic [1:0] {
        MODE_ANNOUNCE  = 2'd0,
        MODE_HEARTBEAT = 2'd1,
        MODE_SWEEP     = 2'd2,
        MODE_LOOKUP    = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] CFG_MASTER_ADDR    = 2'd0;
    localparam logic [1:0] CFG_BROADCAST_ADDR = 2'd1;
    localparam logic [1:0] CFG_HB_TIMEOUT     = 2'd2;

    // Announce flag that marks a repeater
    localparam logic [7:0] REPEATER_BIT = 8'h01;

    // One node record as it travels around the ring
    typedef struct packed {
        logic              online;
        logic [7:0]        id;
        logic [7:0]        fw_maj;
        logic [7:0]        fw_min;
        logic              repeater;
        logic [7:0]        hops;
        logic [7:0]        relay;
        logic signed [7:0] rssi;
        logic [6:0]        heap;
        logic [31:0]       seen;
    } t_rec;

    // One accepted input item
    typedef struct packed {
        t_mode             mode;
        logic [7:0]        node_id;
        logic [7:0]        fw_maj;
        logic [7:0]        fw_min;
        logic [7:0]        flags;
        logic [7:0]        hop;
        logic [7:0]        relay;
        logic signed [7:0] rssi;
        logic [6:0]        heap_pct;
        logic [31:0]       now_ms;
    } t_item;

    // Status from the update unit for the record passing it this cycle
    typedef struct packed {
        logic hit;
        logic claim;
    } t_head_stat;

endpackage

// ----- hw/rtl/nrl_cell.sv -----
// One ring cell: holds one node record and passes it to its neighbor.
module nrl_cell
    import nrl_pkg::*;
(
    input  logic i_clk,
    input  logic i_shift,
    input  t_rec i_rec,
    output t_rec o_rec
);

    t_rec r_rec;

    // Take the neighbor's record while the ring rotates, else hold
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

// ----- hw/rtl/nrl_head.sv -----
// Update unit at the ring head: matches, claims, refreshes and ages one record.
module nrl_head
    import nrl_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  t_rec                              i_rec,
    input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] i_step,
    input  t_item                             i_item,
    input  logic [$clog2(SLOTS+1)-1:0]        i_count,
    input  logic                              i_found,
    input  logic [7:0]                        i_master,
    input  logic [7:0]                        i_bcast,
    input  logic [31:0]                       i_timeout,
    output t_rec                              o_rec,
    output t_head_stat                        o_stat
);

    localparam int CW = $clog2(SLOTS+1);

    logic [CW-1:0] step_ext;
    logic          used;
    logic          match;
    logic          free_here;
    logic          id_ok;
    logic [31:0]   age;

    // Slots fill in order and are never freed, so the used ones come first
    assign step_ext  = CW'(i_step);
    assign used      = step_ext < i_count;
    assign match     = used && (i_rec.id == i_item.node_id);
    assign free_here = step_ext == i_count;
    assign id_ok     = (i_item.node_id != i_master) && (i_item.node_id != i_bcast);
    assign age       = i_item.now_ms - i_rec.seen;

    // Apply the operation to the record passing the head
    always_comb begin
        o_rec        = i_rec;
        o_stat.hit   = 1'b0;
        o_stat.claim = 1'b0;
        unique case (i_item.mode)
            MODE_ANNOUNCE: begin
                // claim the free slot only for a node not found earlier in the scan
                if (id_ok && (match || (free_here && !i_found))) begin
                    o_stat.hit     = 1'b1;
                    o_stat.claim   = !match;
                    o_rec.id       = i_item.node_id;
                    o_rec.fw_maj   = i_item.fw_maj;
                    o_rec.fw_min   = i_item.fw_min;
                    o_rec.repeater = |(i_item.flags & REPEATER_BIT);
                    o_rec.hops     = i_item.hop;
                    o_rec.relay    = i_item.relay;
                    o_rec.seen     = i_item.now_ms;
                    o_rec.online   = 1'b1;
                end
            end
            MODE_HEARTBEAT: begin
                if (match) begin
                    o_stat.hit   = 1'b1;
                    o_rec.seen   = i_item.now_ms;
                    o_rec.online = 1'b1;
                    o_rec.rssi   = i_item.rssi;
                    o_rec.heap   = i_item.heap_pct;
                end
            end
            MODE_SWEEP: begin
                if (used && i_rec.online && (age > i_timeout)) begin
                    o_rec.online = 1'b0;
                end
            end
            MODE_LOOKUP: begin
                o_stat.hit = match;
            end
            default: begin
                o_stat.hit = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/node_registry_with_liveness_top.sv -----
// Top level: node registry kept in a rotating ring of record cells.
// Each item rotates the ring once through the update unit, one slot per cycle,
// and the input stalls until that rotation ends.
// A waiting result stalls the ring on its last step until it is taken.
// Reset (synchronous, active low) empties the table and loads the register defaults.
module node_registry_with_liveness_top
    import nrl_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_node_id,
    input  logic [7:0]        i_fw_major_in,
    input  logic [7:0]        i_fw_minor_in,
    input  logic [7:0]        i_flags,
    input  logic [7:0]        i_hop_in,
    input  logic [7:0]        i_relay_in,
    input  logic signed [7:0] i_rssi_in,
    input  logic [6:0]        i_heap_pct_in,
    input  logic [31:0]       i_now_ms,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [3:0]        o_slot,
    output logic [4:0]        o_registered_count,
    output logic              o_online,
    output logic [7:0]        o_fw_major,
    output logic [7:0]        o_fw_minor,
    output logic              o_repeater,
    output logic [7:0]        o_hops,
    output logic [7:0]        o_relay_source,
    output logic signed [7:0] o_rssi,
    output logic [6:0]        o_heap_pct,
    output logic [31:0]       o_last_seen_ms
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS+1);
    localparam logic [SW-1:0] LAST_STEP = SW'(SLOTS-1);

    // configuration
    logic [7:0]    r_master;
    logic [7:0]    r_bcast;
    logic [31:0]   r_timeout;

    // control
    logic          r_busy;
    logic [SW-1:0] r_step;
    logic [CW-1:0] r_count;
    logic          r_hit;
    logic          r_claim;
    logic          r_out_valid;

    // payload
    t_item         r_item;
    t_rec          r_hit_rec;
    logic [SW-1:0] r_hit_slot;
    t_rec          r_out_rec;
    logic          r_out_acc;
    logic [3:0]    r_out_slot;
    logic [4:0]    r_out_cnt;

    // next-value terms for the finishing step
    logic          n_hit;
    logic          n_acc;
    t_rec          n_rec;
    logic [SW-1:0] n_slot;
    logic [CW-1:0] n_count;

    logic          in_xfer;
    logic          last;
    logic          can_load;
    logic          advance;
    t_rec          head_in;
    t_rec          head_out;
    t_head_stat    head_stat;
    t_rec          cell_out [SLOTS];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign in_xfer     = i_in_valid && !r_busy;
    assign last        = r_step == LAST_STEP;
    assign can_load    = !r_out_valid || !i_out_stall;
    assign advance     = r_busy && (!last || can_load);

    // Ring of cells; cell 0 feeds the head, the head feeds the far end
    for (genvar k = 0; k < SLOTS; k++) begin : g_ring
        t_rec cell_in;
        if (k == SLOTS-1) begin : g_wrap
            assign cell_in = head_out;
        end else begin : g_next
            assign cell_in = cell_out[k+1];
        end
        nrl_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (advance),
            .i_rec   (cell_in),
            .o_rec   (cell_out[k])
        );
    end

    assign head_in = cell_out[0];

    nrl_head #(.SLOTS(SLOTS)) u_head (
        .i_rec     (head_in),
        .i_step    (r_step),
        .i_item    (r_item),
        .i_count   (r_count),
        .i_found   (r_hit),
        .i_master  (r_master),
        .i_bcast   (r_bcast),
        .i_timeout (r_timeout),
        .o_rec     (head_out),
        .o_stat    (head_stat)
    );

    // Merge the hit seen on the last step with the one held from earlier steps
    always_comb begin
        n_hit   = r_hit || head_stat.hit;
        n_rec   = head_stat.hit ? head_out : r_hit_rec;
        n_slot  = head_stat.hit ? r_step : r_hit_slot;
        n_count = r_count + CW'(r_claim || head_stat.claim);
        n_acc   = (r_item.mode == MODE_SWEEP) || n_hit;
        if (!n_hit) begin
            n_rec  = '0;
            n_slot = '0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master  <= 8'd0;
            r_bcast   <= 8'd255;
            r_timeout <= 32'd30000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MASTER_ADDR:    r_master  <= i_cfg_data[7:0];
                CFG_BROADCAST_ADDR: r_bcast   <= i_cfg_data[7:0];
                CFG_HB_TIMEOUT:     r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Scan sequencing, table count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_count     <= '0;
            r_hit       <= 1'b0;
            r_claim     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result on the finishing step, drop it once taken
            if (advance && last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_xfer) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_hit   <= 1'b0;
                r_claim <= 1'b0;
            end else if (advance) begin
                if (head_stat.claim) begin
                    r_claim <= 1'b1;
                end
                if (head_stat.hit) begin
                    r_hit <= 1'b1;
                end
                if (last) begin
                    r_busy  <= 1'b0;
                    r_step  <= '0;
                    r_count <= n_count;
                end else begin
                    r_step <= r_step + SW'(1);
                end
            end
        end
    end

    // Payload: hold the item, the found record and the result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.mode     <= t_mode'(i_mode);
            r_item.node_id  <= i_node_id;
            r_item.fw_maj   <= i_fw_major_in;
            r_item.fw_min   <= i_fw_minor_in;
            r_item.flags    <= i_flags;
            r_item.hop      <= i_hop_in;
            r_item.relay    <= i_relay_in;
            r_item.rssi     <= i_rssi_in;
            r_item.heap_pct <= i_heap_pct_in;
            r_item.now_ms   <= i_now_ms;
        end
        if (advance && head_stat.hit) begin
            r_hit_rec  <= head_out;
            r_hit_slot <= r_step;
        end
        if (advance && last) begin
            r_out_rec  <= n_rec;
            r_out_acc  <= n_acc;
            r_out_slot <= 4'(n_slot);
            r_out_cnt  <= 5'(n_count);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_out_acc;
    assign o_slot             = r_out_slot;
    assign o_registered_count = r_out_cnt;
    assign o_online           = r_out_rec.online;
    assign o_fw_major         = r_out_rec.fw_maj;
    assign o_fw_minor         = r_out_rec.fw_min;
    assign o_repeater         = r_out_rec.repeater;
    assign o_hops             = r_out_rec.hops;
    assign o_relay_source     = r_out_rec.relay;
    assign o_rssi             = r_out_rec.rssi;
    assign o_heap_pct         = r_out_rec.heap;
    assign o_last_seen_ms     = r_out_rec.seen;

endmodule

// ----- hw/rtl/nrl_checker.sv -----
// Port-level checks for the node registry, bound to the top level.
module nrl_checker #(
    parameter int SLOTS = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_accepted,
    input logic [3:0]        o_slot,
    input logic [4:0]        o_registered_count,
    input logic              o_online,
    input logic [31:0]       o_last_seen_ms
);

    // Block further transfers while an item is in the ring
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A rejected item carries no record
    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |->
            (o_slot == 4'd0 && !o_online && o_last_seen_ms == 32'd0))
        else $error("rejected result carries record data");

    // The count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_registered_count) <= 32'(SLOTS)))
        else $error("registered count beyond table size");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_slot) && $stable(o_registered_count)))
        else $error("stalled result changed");

endmodule

bind node_registry_with_liveness_top nrl_checker #(.SLOTS(SLOTS)) u_nrl_checker (.*);

// ----- bench/node_registry_with_liveness_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the node registry with liveness tracking.
module node_registry_with_liveness_top_test;
    import nrl_pkg::*;

    localparam int NODES          = 16;
    localparam int POOL_SIZE      = 24;
    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 356;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_ITEMS     = 12;
    localparam int SETTLE_CYCLES  = NODES + 4;
    localparam int WATCHDOG_LIMIT = 5000;

    // One expected result; rssi and heap are only known once a heartbeat wrote them
    typedef struct {
        logic              accepted;
        logic [3:0]        slot;
        logic [4:0]        count;
        logic              online;
        logic [7:0]        fw_maj;
        logic [7:0]        fw_min;
        logic              repeater;
        logic [7:0]        hops;
        logic [7:0]        relay;
        logic signed [7:0] rssi;
        logic [6:0]        heap;
        logic [31:0]       seen;
        bit                health_known;
    } t_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = CFG_MASTER_ADDR;
    logic [31:0]       i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_mode = MODE_LOOKUP;
    logic [7:0]        i_node_id = '0;
    logic [7:0]        i_fw_major_in = '0;
    logic [7:0]        i_fw_minor_in = '0;
    logic [7:0]        i_flags = '0;
    logic [7:0]        i_hop_in = '0;
    logic [7:0]        i_relay_in = '0;
    logic signed [7:0] i_rssi_in = '0;
    logic [6:0]        i_heap_pct_in = '0;
    logic [31:0]       i_now_ms = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_accepted;
    logic [3:0]        o_slot;
    logic [4:0]        o_registered_count;
    logic              o_online;
    logic [7:0]        o_fw_major;
    logic [7:0]        o_fw_minor;
    logic              o_repeater;
    logic [7:0]        o_hops;
    logic [7:0]        o_relay_source;
    logic signed [7:0] o_rssi;
    logic [6:0]        o_heap_pct;
    logic [31:0]       o_last_seen_ms;

    // Predicted registry contents and register copies
    logic [7:0]        cfg_master  = 8'd0;
    logic [7:0]        cfg_bcast   = 8'd255;
    logic [31:0]       cfg_timeout = 32'd30000;
    logic              tbl_used   [NODES] = '{default: 1'b0};
    logic              tbl_online [NODES] = '{default: 1'b0};
    logic [7:0]        tbl_id     [NODES] = '{default: 8'd0};
    logic [7:0]        tbl_fw_maj [NODES] = '{default: 8'd0};
    logic [7:0]        tbl_fw_min [NODES] = '{default: 8'd0};
    logic              tbl_rep    [NODES] = '{default: 1'b0};
    logic [7:0]        tbl_hops   [NODES] = '{default: 8'd0};
    logic [7:0]        tbl_relay  [NODES] = '{default: 8'd0};
    logic signed [7:0] tbl_rssi   [NODES] = '{default: 8'd0};
    logic [6:0]        tbl_heap   [NODES] = '{default: 7'd0};
    logic [31:0]       tbl_seen   [NODES] = '{default: 32'd0};
    bit                tbl_hb     [NODES] = '{default: 1'b0};

    t_status     replies_due [$];
    logic [7:0]  id_pool [POOL_SIZE];
    logic [31:0] wall_ms = 32'd0;
    int          failures = 0;
    int          idle_cycles = 0;
    bit          gaps_on = 1'b1;
    int          burst_left = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          pattern_left = 0;
    int          pattern_kind = 0;

    node_registry_with_liveness_top #(
        .SLOTS(NODES)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_mode             (i_mode),
        .i_node_id          (i_node_id),
        .i_fw_major_in      (i_fw_major_in),
        .i_fw_minor_in      (i_fw_minor_in),
        .i_flags            (i_flags),
        .i_hop_in           (i_hop_in),
        .i_relay_in         (i_relay_in),
        .i_rssi_in          (i_rssi_in),
        .i_heap_pct_in      (i_heap_pct_in),
        .i_now_ms           (i_now_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_slot             (o_slot),
        .o_registered_count (o_registered_count),
        .o_online           (o_online),
        .o_fw_major         (o_fw_major),
        .o_fw_minor         (o_fw_minor),
        .o_repeater         (o_repeater),
        .o_hops             (o_hops),
        .o_relay_source     (o_relay_source),
        .o_rssi             (o_rssi),
        .o_heap_pct         (o_heap_pct),
        .o_last_seen_ms     (o_last_seen_ms)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Slot holding this id, or -1
    function automatic int find_slot(input logic [7:0] id);
        for (int i = 0; i < NODES; i++) begin
            if (tbl_used[i] && tbl_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one item to the predicted table and return the result it causes
    function automatic t_status registry_update(input t_item it);
        t_status     r;
        int          hit;
        bit          ok;
        int          n;
        logic [31:0] silence;
        r = '{default: 0};
        hit = -1;
        ok = 1'b0;
        n = 0;
        case (it.mode)
            MODE_ANNOUNCE: begin
                if (it.node_id != cfg_master && it.node_id != cfg_bcast) begin
                    hit = find_slot(it.node_id);
                    // claim the first free slot for a new node
                    for (int i = 0; i < NODES && hit < 0; i++) begin
                        if (!tbl_used[i]) begin
                            hit = i;
                            tbl_used[i] = 1'b1;
                            tbl_id[i] = it.node_id;
                        end
                    end
                    if (hit >= 0) begin
                        tbl_fw_maj[hit] = it.fw_maj;
                        tbl_fw_min[hit] = it.fw_min;
                        tbl_rep[hit]    = |(it.flags & REPEATER_BIT);
                        tbl_hops[hit]   = it.hop;
                        tbl_relay[hit]  = it.relay;
                        tbl_seen[hit]   = it.now_ms;
                        tbl_online[hit] = 1'b1;
                        ok = 1'b1;
                    end
                end
            end
            MODE_HEARTBEAT: begin
                hit = find_slot(it.node_id);
                if (hit >= 0) begin
                    tbl_seen[hit]   = it.now_ms;
                    tbl_online[hit] = 1'b1;
                    tbl_rssi[hit]   = it.rssi;
                    tbl_heap[hit]   = it.heap_pct;
                    tbl_hb[hit]     = 1'b1;
                    ok = 1'b1;
                end
            end
            MODE_SWEEP: begin
                for (int i = 0; i < NODES; i++) begin
                    silence = it.now_ms - tbl_seen[i];
                    if (tbl_used[i] && tbl_online[i] && silence > cfg_timeout) begin
                        tbl_online[i] = 1'b0;
                    end
                end
                ok = 1'b1;
            end
            default: begin
                hit = find_slot(it.node_id);
                ok = (hit >= 0);
            end
        endcase
        for (int i = 0; i < NODES; i++) begin
            n += tbl_used[i];
        end
        r.accepted = ok;
        r.count = n[4:0];
        r.health_known = 1'b1;
        if (ok && hit >= 0) begin
            r.slot         = hit[3:0];
            r.online       = tbl_online[hit];
            r.fw_maj       = tbl_fw_maj[hit];
            r.fw_min       = tbl_fw_min[hit];
            r.repeater     = tbl_rep[hit];
            r.hops         = tbl_hops[hit];
            r.relay        = tbl_relay[hit];
            r.rssi         = tbl_rssi[hit];
            r.heap         = tbl_heap[hit];
            r.seen         = tbl_seen[hit];
            r.health_known = tbl_hb[hit];
        end
        return r;
    endfunction

    function automatic t_item mk(input t_mode m, input logic [7:0] id,
                                 input logic [7:0] fwa, input logic [7:0] fwb,
                                 input logic [7:0] flg, input logic [7:0] hop,
                                 input logic [7:0] rly, input logic [7:0] rssi,
                                 input logic [6:0] heap, input logic [31:0] now);
        t_item it;
        it.mode     = m;
        it.node_id  = id;
        it.fw_maj   = fwa;
        it.fw_min   = fwb;
        it.flags    = flg;
        it.hop      = hop;
        it.relay    = rly;
        it.rssi     = rssi;
        it.heap_pct = heap;
        it.now_ms   = now;
        return it;
    endfunction

    // Mostly known ids, some reserved and random ones; sweeps aimed at the timeout edge
    function automatic t_item random_item();
        t_item it;
        int    roll;
        int    k;
        roll = $urandom_range(0, 99);
        if (roll < 35)      it.mode = MODE_ANNOUNCE;
        else if (roll < 65) it.mode = MODE_HEARTBEAT;
        else if (roll < 75) it.mode = MODE_SWEEP;
        else                it.mode = MODE_LOOKUP;
        roll = $urandom_range(0, 99);
        if (roll < 80)      it.node_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (roll < 84) it.node_id = cfg_master;
        else if (roll < 88) it.node_id = cfg_bcast;
        else                it.node_id = 8'($urandom_range(0, 255));
        it.fw_maj   = 8'($urandom_range(0, 255));
        it.fw_min   = 8'($urandom_range(0, 255));
        it.flags    = 8'($urandom_range(0, 255));
        it.hop      = 8'($urandom_range(0, 255));
        it.relay    = 8'($urandom_range(0, 255));
        it.rssi     = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 9);
        if (roll == 0)      it.heap_pct = 7'd0;
        else if (roll == 1) it.heap_pct = 7'd100;
        else                it.heap_pct = 7'($urandom_range(0, 100));
        if ($urandom_range(0, 99) < 3) wall_ms = $urandom;
        else                           wall_ms += $urandom_range(0, 1500);
        it.now_ms = wall_ms;
        k = $urandom_range(0, NODES - 1);
        if (it.mode == MODE_SWEEP && tbl_used[k] && $urandom_range(0, 9) < 6) begin
            it.now_ms = tbl_seen[k] + cfg_timeout + 32'($urandom_range(0, 2)) - 32'd1;
        end
        // a node with no heartbeat yet has no health data to report
        k = find_slot(it.node_id);
        if (it.mode == MODE_LOOKUP && k >= 0 && !tbl_hb[k]) begin
            it.mode = MODE_HEARTBEAT;
        end
        return it;
    endfunction

    // Drop the input, let every result drain, then let the ring settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MASTER_ADDR:    cfg_master  = value[7:0];
            CFG_BROADCAST_ADDR: cfg_bcast   = value[7:0];
            CFG_HB_TIMEOUT:     cfg_timeout = value;
            default: ;
        endcase
    endtask

    // Offer one item, in bursts with random gaps, and predict it once transferred
    task automatic send_item(input t_item it);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                burst_left = $urandom_range(0, 12);
            end
        end
        i_in_valid    <= 1'b1;
        i_mode        <= it.mode;
        i_node_id     <= it.node_id;
        i_fw_major_in <= it.fw_maj;
        i_fw_minor_in <= it.fw_min;
        i_flags       <= it.flags;
        i_hop_in      <= it.hop;
        i_relay_in    <= it.relay;
        i_rssi_in     <= it.rssi;
        i_heap_pct_in <= it.heap_pct;
        i_now_ms      <= it.now_ms;
        do @(posedge i_clk); while (o_in_stall);
        replies_due.push_back(registry_update(it));
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_reply
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                failures++;
            end else begin
                want = replies_due.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                check_field("slot", 32'(want.slot), 32'(o_slot));
                check_field("registered_count", 32'(want.count), 32'(o_registered_count));
                check_field("online", 32'(want.online), 32'(o_online));
                check_field("o_fw_major", 32'(want.fw_maj), 32'(o_fw_major));
                check_field("o_fw_minor", 32'(want.fw_min), 32'(o_fw_minor));
                check_field("repeater", 32'(want.repeater), 32'(o_repeater));
                check_field("hops", 32'(want.hops), 32'(o_hops));
                check_field("relay_source", 32'(want.relay), 32'(o_relay_source));
                check_field("last_seen_ms", want.seen, o_last_seen_ms);
                if (want.health_known) begin
                    check_field("rssi", 32'(want.rssi), 32'(o_rssi));
                    check_field("heap_pct", 32'(want.heap), 32'(o_heap_pct));
                end
            end
        end
    end

    // Receiver stall: a changing pattern, overridden by long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left == 0 && holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (pattern_left == 0) begin
            pattern_kind = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 300);
        end
        pattern_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (pattern_kind)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                2:       i_out_stall <= ($urandom_range(0, 99) < 75);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Empty table: unknown nodes, sweep, reserved ids
    task automatic test_reset_state();
        send_item(mk(MODE_LOOKUP, 8'd1, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_HEARTBEAT, 8'd1, 0, 0, 0, 0, 0, 8'h11, 7'd50, 32'd10));
        send_item(mk(MODE_SWEEP, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_ANNOUNCE, 8'd0, 8'd1, 8'd1, 8'h01, 8'd1, 8'd1, 0, 0, 32'd20));
        send_item(mk(MODE_ANNOUNCE, 8'd255, 8'd1, 8'd1, 8'h01, 8'd1, 8'd1, 0, 0, 32'd30));
    endtask

    // Register two nodes with extreme fields, add health data, read back, refresh
    task automatic test_announce_refresh();
        send_item(mk(MODE_ANNOUNCE, 8'd1, 8'd255, 8'd0, 8'hFF, 8'd255, 8'd0,
                     0, 0, 32'd100));
        send_item(mk(MODE_ANNOUNCE, 8'd254, 8'd0, 8'd255, 8'hFE, 8'd0, 8'd255,
                     0, 0, 32'hFFFF_FFFF));
        send_item(mk(MODE_HEARTBEAT, 8'd1, 0, 0, 0, 0, 0, 8'h80, 7'd100, 32'd200));
        send_item(mk(MODE_HEARTBEAT, 8'd254, 0, 0, 0, 0, 0, 8'h7F, 7'd0, 32'd5));
        send_item(mk(MODE_LOOKUP, 8'd1, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_LOOKUP, 8'd254, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_ANNOUNCE, 8'd1, 8'd1, 8'd2, 8'h01, 8'd3, 8'd4, 0, 0, 32'd300));
    endtask

    // Silence exactly at, and one past, the timeout; then across the 32-bit wrap
    task automatic test_sweep_boundary();
        write_register(CFG_HB_TIMEOUT, 32'd1000);
        send_item(mk(MODE_SWEEP, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'd1300));
        send_item(mk(MODE_LOOKUP, 8'd1, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_LOOKUP, 8'd254, 0, 0, 0, 0, 0, 0, 0, 32'd0));
        send_item(mk(MODE_SWEEP, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'd1301));
        send_item(mk(MODE_HEARTBEAT, 8'd254, 0, 0, 0, 0, 0, 8'h01, 7'd64,
                     32'hFFFF_FF00));
        send_item(mk(MODE_SWEEP, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_02E8));
        send_item(mk(MODE_LOOKUP, 8'd254, 0, 0, 0, 0, 0, 0, 0, 32'd0));
    endtask

    // Swapped and coinciding reserved ids, zero timeout
    task automatic test_config_extremes();
        write_register(CFG_MASTER_ADDR, 32'd255);
        write_register(CFG_BROADCAST_ADDR, 32'd0);
        write_register(CFG_HB_TIMEOUT, 32'd0);
        send_item(mk(MODE_ANNOUNCE, 8'd255, 8'd9, 8'd9, 0, 0, 0, 0, 0, 32'd400));
        send_item(mk(MODE_ANNOUNCE, 8'd0, 8'd9, 8'd9, 0, 0, 0, 0, 0, 32'd400));
        write_register(CFG_MASTER_ADDR, 32'd1);
        write_register(CFG_BROADCAST_ADDR, 32'd1);
        send_item(mk(MODE_ANNOUNCE, 8'd1, 8'd7, 8'd7, 0, 0, 0, 0, 0, 32'd500));
        send_item(mk(MODE_HEARTBEAT, 8'd1, 0, 0, 0, 0, 0, 8'h40, 7'd1, 32'd600));
        send_item(mk(MODE_SWEEP, 8'd0, 0, 0, 0, 0, 0, 0, 0, 32'd600));
    endtask

    // Hold the output off while items keep coming, so the block backs up
    task automatic test_output_holdoff();
        gaps_on = 1'b0;
        hold_requests++;
        repeat (HOLD_ITEMS) send_item(random_item());
        gaps_on = 1'b1;
    endtask

    // Random traffic over several register settings
    task automatic test_random_traffic();
        logic [7:0]  m;
        logic [7:0]  b;
        logic [31:0] t;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    m = 8'd0;
                    b = 8'd255;
                    t = 32'd30000;
                end
                1: begin
                    m = 8'd255;
                    b = 8'd0;
                    t = 32'd0;
                end
                2: begin
                    m = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                    b = m;
                    t = 32'hFFFF_FFFF;
                end
                3: begin
                    m = 8'($urandom_range(0, 255));
                    b = 8'($urandom_range(0, 255));
                    t = $urandom_range(1, 100000);
                end
                default: begin
                    m = 8'd0;
                    b = 8'd255;
                    t = $urandom;
                end
            endcase
            write_register(CFG_MASTER_ADDR, {24'd0, m});
            write_register(CFG_BROADCAST_ADDR, {24'd0, b});
            write_register(CFG_HB_TIMEOUT, t);
            repeat (PHASE_ITEMS) send_item(random_item());
        end
    endtask

    initial begin
        // more ids than slots, so the table fills and then rejects newcomers
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = 8'($urandom_range(1, 254));
        end
        id_pool[0] = 8'd1;
        id_pool[1] = 8'd254;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_announce_refresh();
        test_sweep_boundary();
        test_config_extremes();
        test_output_holdoff();
        test_random_traffic();
        wait_idle();
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
